FILE: design/gsut_pkg.sv
// ----------------------------------------------------------------------------
// gsut_pkg
// Shared types and constants for the gas sensor UART command/reply block.
// ----------------------------------------------------------------------------
package gsut_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
	localparam int RX_CNT_W = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] ADDR_BYTE = 8'h01;
	localparam logic [15:0] DEFAULT_TIMEOUT = 16'd30000;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_RX = 2'd1,
		REQ_CMD = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		KIND_TX = 2'd0,
		KIND_OK = 2'd1,
		KIND_BAD = 2'd2,
		KIND_TIMEOUT = 2'd3
	} out_kind_t;

	typedef struct packed {
		req_kind_t req_type;
		logic [7:0] command_code;
		logic [7:0] arg_byte;
		logic [31:0] arg_word;
		logic want_reply;
		logic [7:0] rx_data;
	} req_t;

	typedef struct packed {
		out_kind_t out_kind;
		logic [7:0] tx_data;
		logic [15:0] ppm;
		logic last;
	} res_t;

	typedef struct packed {
		logic valid;
		logic frame;
		out_kind_t kind;
		logic [15:0] ppm;
		logic [FRAME_BYTES-1:0][7:0] bytes;
	} load_t;

endpackage

FILE: design/gsut_proc.sv
// ----------------------------------------------------------------------------
// gsut_proc
// Input register and exchange state: builds command frames, collects reply
// bytes, checks the checksum and counts millisecond ticks toward a timeout.
// ----------------------------------------------------------------------------
module gsut_proc (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  gsut_pkg::req_t in_word,
	input  logic can_load,
	output gsut_pkg::load_t load
);

	logic valid_s1;
	gsut_pkg::req_t word_s1;
	logic advance;

	logic [15:0] timeout_q;
	logic awaiting_q, awaiting_d;
	logic [gsut_pkg::RX_CNT_W-1:0] rx_count_q, rx_count_d;
	logic [7:0] rx_sum_q, rx_sum_d;
	logic [7:0] level_high_q, level_high_d;
	logic [7:0] level_low_q, level_low_d;
	logic [15:0] elapsed_q, elapsed_d;

	logic [gsut_pkg::FRAME_BYTES-1:0][7:0] frame;
	logic [7:0] sum;
	logic [7:0] expect_sum;

	assign advance = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;
	assign expect_sum = 8'(8'd0 - rx_sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

	// command frame
	always_comb begin
		frame[0] = gsut_pkg::SYNC_BYTE;
		frame[1] = gsut_pkg::ADDR_BYTE;
		frame[2] = word_s1.command_code;
		frame[3] = word_s1.arg_byte;
		frame[4] = word_s1.arg_word[31:24];
		frame[5] = word_s1.arg_word[23:16];
		frame[6] = word_s1.arg_word[15:8];
		frame[7] = word_s1.arg_word[7:0];
		sum = 8'd0;
		for (int i = 1; i < gsut_pkg::FRAME_BYTES - 1; i++) begin
			sum = 8'(sum + frame[i]);
		end
		frame[gsut_pkg::FRAME_BYTES-1] = 8'(8'd0 - sum);
	end

	always_comb begin
		awaiting_d = awaiting_q;
		rx_count_d = rx_count_q;
		rx_sum_d = rx_sum_q;
		level_high_d = level_high_q;
		level_low_d = level_low_q;
		elapsed_d = elapsed_q;
		load.valid = 1'b0;
		load.frame = 1'b0;
		load.kind = gsut_pkg::KIND_TX;
		load.ppm = 16'd0;
		load.bytes = frame;
		if (advance) begin
			unique case (word_s1.req_type)
				gsut_pkg::REQ_CMD: begin
					load.valid = 1'b1;
					load.frame = 1'b1;
					awaiting_d = word_s1.want_reply;
					rx_count_d = '0;
					rx_sum_d = 8'd0;
					elapsed_d = 16'd0;
				end
				gsut_pkg::REQ_RX: begin
					if (awaiting_q) begin
						if (rx_count_q >= gsut_pkg::RX_CNT_W'(1) &&
								rx_count_q <= gsut_pkg::RX_CNT_W'(gsut_pkg::FRAME_BYTES - 2)) begin
							rx_sum_d = 8'(rx_sum_q + word_s1.rx_data);
						end
						if (rx_count_q == gsut_pkg::RX_CNT_W'(2)) begin
							level_high_d = word_s1.rx_data;
						end
						if (rx_count_q == gsut_pkg::RX_CNT_W'(3)) begin
							level_low_d = word_s1.rx_data;
						end
						if (rx_count_q >= gsut_pkg::RX_CNT_W'(gsut_pkg::FRAME_BYTES - 1)) begin
							awaiting_d = 1'b0;
							rx_count_d = '0;
							load.valid = 1'b1;
							if (word_s1.rx_data == expect_sum) begin
								load.kind = gsut_pkg::KIND_OK;
								load.ppm = {level_high_q, level_low_q};
							end else begin
								load.kind = gsut_pkg::KIND_BAD;
							end
						end else begin
							rx_count_d = gsut_pkg::RX_CNT_W'(rx_count_q + 1'b1);
						end
					end
				end
				gsut_pkg::REQ_TICK: begin
					if (awaiting_q) begin
						if (elapsed_q != 16'hFFFF) begin
							elapsed_d = 16'(elapsed_q + 1'b1);
						end
						if (elapsed_d >= timeout_q) begin
							awaiting_d = 1'b0;
							rx_count_d = '0;
							load.valid = 1'b1;
							load.kind = gsut_pkg::KIND_TIMEOUT;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= gsut_pkg::DEFAULT_TIMEOUT;
			awaiting_q <= 1'b0;
			rx_count_q <= '0;
			rx_sum_q <= 8'd0;
			level_high_q <= 8'd0;
			level_low_q <= 8'd0;
			elapsed_q <= 16'd0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			awaiting_q <= awaiting_d;
			rx_count_q <= rx_count_d;
			rx_sum_q <= rx_sum_d;
			level_high_q <= level_high_d;
			level_low_q <= level_low_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

FILE: design/gsut_tx.sv
// ----------------------------------------------------------------------------
// gsut_tx
// Result register: holds one reply result or a command frame and hands the
// frame out one byte per output word.
// ----------------------------------------------------------------------------
module gsut_tx (
	input  logic clk,
	input  logic arst_n,
	input  gsut_pkg::load_t load,
	output logic can_load,
	output logic out_final,
	output logic out_valid,
	input  logic out_ready,
	output gsut_pkg::res_t out_word
);

	logic valid_q;
	logic frame_q;
	logic [gsut_pkg::IDX_W-1:0] idx_q;
	logic [gsut_pkg::FRAME_BYTES-1:0][7:0] bytes_q;
	gsut_pkg::out_kind_t kind_q;
	logic [15:0] ppm_q;

	assign out_valid = valid_q;
	assign out_final = !frame_q || idx_q == gsut_pkg::LAST_IDX;
	assign can_load = !valid_q || (out_ready && out_final);

	always_comb begin
		if (frame_q) begin
			out_word.out_kind = gsut_pkg::KIND_TX;
			out_word.tx_data = bytes_q[idx_q];
			out_word.ppm = 16'd0;
			out_word.last = idx_q == gsut_pkg::LAST_IDX;
		end else begin
			out_word.out_kind = kind_q;
			out_word.tx_data = 8'd0;
			out_word.ppm = ppm_q;
			out_word.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			frame_q <= 1'b0;
			idx_q <= '0;
		end else if (load.valid) begin
			valid_q <= 1'b1;
			frame_q <= load.frame;
			idx_q <= '0;
		end else if (valid_q && out_ready) begin
			if (out_final) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= gsut_pkg::IDX_W'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			bytes_q <= load.bytes;
			kind_q <= load.kind;
			ppm_q <= load.ppm;
		end
	end

endmodule

FILE: design/gas_sensor_uart_transaction.sv
// ----------------------------------------------------------------------------
// gas_sensor_uart_transaction
// Nine-byte command/reply exchange with a gas sensor over a UART byte stream.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    gsut_pkg::req_t
//   out      output     out_valid / out_ready  gsut_pkg::res_t
//   cfg      input      cfg_wr_en              timeout_ms (16 bits)
//
// A tick or received byte passes the input register and then the state logic;
// one word per cycle while the result register is empty or is
// handing out its final word, whether or not the word gives a result.
// A command gives nine output words from the result register, one per cycle
// while out_ready is high, so it holds the output until its last byte is taken;
// the next word waits in the input register meanwhile. Reset clears the exchange state and loads timeout 30000.
// Out stalls hold the result register and then the input register.
// ----------------------------------------------------------------------------
module gas_sensor_uart_transaction (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  gsut_pkg::req_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output gsut_pkg::res_t out_word
);

	gsut_pkg::load_t load;
	logic can_load;
	logic out_final;

	gsut_proc u_proc (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.can_load(can_load),
		.load(load)
	);

	gsut_tx u_tx (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.can_load(can_load),
		.out_final(out_final),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	// a result is only loaded when the result register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load.valid |-> can_load)
		else $error("result loaded over pending word");

	// a loaded frame shows its start byte next cycle
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		load.valid && load.frame |=> out_valid &&
			out_word.out_kind == gsut_pkg::KIND_TX &&
			out_word.tx_data == gsut_pkg::SYNC_BYTE)
		else $error("frame start missing");

	// a frame is not cut short
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_final |=> out_valid &&
			out_word.out_kind == gsut_pkg::KIND_TX)
		else $error("frame cut short");

	// last only marks transmit bytes
	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.last |-> out_word.out_kind == gsut_pkg::KIND_TX)
		else $error("last on non-transmit word");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gas sensor UART command/reply block. A driver
// feeds request words from a queue, a monitor predicts every output word from
// the accepted requests and compares it field by field. Covers idle bytes and
// ticks, command frames, good and bad replies, aborted waits and timeouts at
// several timeout settings, under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [7:0] CMD_READ = 8'h86;
	localparam logic [7:0] CMD_RANGE = 8'h99;
	localparam logic [7:0] CMD_AUTOCAL = 8'h79;
	localparam logic [7:0] CAL_ENABLE = 8'hA0;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	gsut_pkg::req_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	gsut_pkg::res_t out_word;

	// predicted exchange state
	logic [15:0] limit_ms = gsut_pkg::DEFAULT_TIMEOUT;
	logic waiting = 1'b0;
	logic [3:0] rx_pos = '0;
	logic [7:0] rx_acc = '0;
	logic [7:0] level_hi = '0;
	logic [7:0] level_lo = '0;
	logic [15:0] elapsed = '0;

	gsut_pkg::res_t expected_words[$];
	gsut_pkg::req_t pending_words[$];
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned items_made = 0;
	int unsigned errors = 0;
	int unsigned quiet = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	bit in_taken = 1'b0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_ask = 1'b0;
	bit hold_done = 1'b0;

	gas_sensor_uart_transaction u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic gsut_pkg::res_t result_word(gsut_pkg::out_kind_t k, logic [7:0] tx,
		logic [15:0] level, logic fin);
		gsut_pkg::res_t r;
		r.out_kind = k;
		r.tx_data = tx;
		r.ppm = level;
		r.last = fin;
		return r;
	endfunction

	function automatic void predict_exchange(gsut_pkg::req_t w);
		logic [7:0] frame [0:gsut_pkg::FRAME_BYTES-1];
		logic [7:0] sum;
		logic [7:0] chk;
		logic [3:0] pos;
		sum = '0;
		pos = rx_pos;
		case (w.req_type)
			gsut_pkg::REQ_CMD: begin
				frame[0] = gsut_pkg::SYNC_BYTE;
				frame[1] = gsut_pkg::ADDR_BYTE;
				frame[2] = w.command_code;
				frame[3] = w.arg_byte;
				frame[4] = w.arg_word[31:24];
				frame[5] = w.arg_word[23:16];
				frame[6] = w.arg_word[15:8];
				frame[7] = w.arg_word[7:0];
				for (int i = 1; i < gsut_pkg::FRAME_BYTES - 1; i++)
					sum += frame[i];
				frame[gsut_pkg::FRAME_BYTES-1] = -sum;
				for (int i = 0; i < gsut_pkg::FRAME_BYTES; i++)
					expected_words.push_back(result_word(gsut_pkg::KIND_TX, frame[i], '0,
						i == gsut_pkg::FRAME_BYTES - 1));
				waiting = w.want_reply;
				rx_pos = '0;
				rx_acc = '0;
				elapsed = '0;
			end
			gsut_pkg::REQ_RX: if (waiting) begin
				if (pos >= 1 && pos <= gsut_pkg::FRAME_BYTES - 2)
					rx_acc += w.rx_data;
				if (pos == 2)
					level_hi = w.rx_data;
				if (pos == 3)
					level_lo = w.rx_data;
				if (pos >= gsut_pkg::FRAME_BYTES - 1) begin
					waiting = 1'b0;
					rx_pos = '0;
					chk = -rx_acc;
					if (w.rx_data == chk)
						expected_words.push_back(result_word(gsut_pkg::KIND_OK, '0,
							{level_hi, level_lo}, 1'b0));
					else
						expected_words.push_back(result_word(gsut_pkg::KIND_BAD, '0, '0,
							1'b0));
				end else begin
					rx_pos = pos + 4'd1;
				end
			end
			gsut_pkg::REQ_TICK: if (waiting) begin
				if (elapsed != 16'hFFFF)
					elapsed++;
				if (elapsed >= limit_ms) begin
					waiting = 1'b0;
					rx_pos = '0;
					expected_words.push_back(result_word(gsut_pkg::KIND_TIMEOUT, '0, '0,
						1'b0));
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : monitor
		gsut_pkg::res_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			predict_exchange(in_word);
			words_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d tx %0h ppm %0h last %0b",
					out_word.out_kind, out_word.tx_data, out_word.ppm, out_word.last);
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("out_kind", want.out_kind, out_word.out_kind);
				check_field("tx_data", want.tx_data, out_word.tx_data);
				check_field("ppm", want.ppm, out_word.ppm);
				check_field("last", want.last, out_word.last);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin : driver
		logic nxt_valid;
		gsut_pkg::req_t nxt_word;
		nxt_valid = in_valid;
		nxt_word = in_word;
		if (in_taken)
			nxt_valid = 1'b0;
		if (!nxt_valid && arst_n) begin
			if (send_gap != 0)
				send_gap--;
			else if (send_idle && $urandom_range(0, 9) == 0)
				send_gap = $urandom_range(1, 14) - 1;
			else if (pending_words.size() != 0) begin
				nxt_valid = 1'b1;
				nxt_word = pending_words.pop_front();
			end
		end
		in_valid <= nxt_valid;
		in_word <= nxt_word;
	end

	always @(negedge clk) begin : receiver
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_ask && !hold_done) begin
			// long stall so the block backs up into its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic gsut_pkg::req_t any_word(gsut_pkg::req_kind_t k);
		gsut_pkg::req_t w;
		w.req_type = k;
		w.command_code = 8'($urandom);
		w.arg_byte = 8'($urandom);
		w.arg_word = $urandom;
		w.want_reply = 1'($urandom);
		w.rx_data = 8'($urandom);
		return w;
	endfunction

	task automatic offer(gsut_pkg::req_t w, bit counted);
		pending_words.push_back(w);
		words_queued++;
		if (counted)
			items_made++;
	endtask

	task automatic offer_cmd(logic [7:0] code, logic [7:0] a8, logic [31:0] a32, bit want);
		gsut_pkg::req_t w;
		w = any_word(gsut_pkg::REQ_CMD);
		w.command_code = code;
		w.arg_byte = a8;
		w.arg_word = a32;
		w.want_reply = want;
		offer(w, 1'b1);
	endtask

	task automatic offer_rx(logic [7:0] b);
		gsut_pkg::req_t w;
		w = any_word(gsut_pkg::REQ_RX);
		w.rx_data = b;
		offer(w, 1'b1);
	endtask

	task automatic offer_ticks(int unsigned n);
		repeat (n) offer(any_word(gsut_pkg::REQ_TICK), 1'b1);
	endtask

	task automatic offer_reply(logic [7:0] hi, logic [7:0] lo, bit good, bit with_ticks);
		logic [7:0] frame_b [0:gsut_pkg::FRAME_BYTES-1];
		logic [7:0] sum;
		sum = '0;
		// start byte is not checked by the block
		frame_b[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : gsut_pkg::SYNC_BYTE;
		frame_b[1] = CMD_READ;
		frame_b[2] = hi;
		frame_b[3] = lo;
		for (int i = 4; i < gsut_pkg::FRAME_BYTES - 1; i++)
			frame_b[i] = 8'($urandom);
		for (int i = 1; i < gsut_pkg::FRAME_BYTES - 1; i++)
			sum += frame_b[i];
		frame_b[gsut_pkg::FRAME_BYTES-1] = -sum;
		if (!good)
			frame_b[gsut_pkg::FRAME_BYTES-1] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < gsut_pkg::FRAME_BYTES; i++) begin
			if (with_ticks && $urandom_range(0, 5) == 0)
				offer(any_word(gsut_pkg::REQ_TICK), 1'b1);
			offer_rx(frame_b[i]);
		end
	endtask

	task automatic settle();
		while (words_taken != words_queued || expected_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_ms = v;
	endtask

	task automatic random_exchange();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			offer_cmd(($urandom_range(0, 2) == 0) ? 8'($urandom) : CMD_READ, 8'($urandom),
				$urandom, 1'b1);
			offer_reply(8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0, 1'b1);
		end else if (pick == 6) begin
			if ($urandom_range(0, 1) == 1)
				offer_cmd(CMD_AUTOCAL, ($urandom_range(0, 1) == 1) ? CAL_ENABLE : 8'h00,
					$urandom, 1'b0);
			else
				offer_cmd(CMD_RANGE, 8'($urandom), $urandom, 1'b0);
		end else if (pick == 7) begin
			// partial reply, left for the next command to abort
			offer_cmd(CMD_READ, 8'($urandom), $urandom, 1'b1);
			n = $urandom_range(1, gsut_pkg::FRAME_BYTES - 1);
			repeat (n) offer_rx(8'($urandom));
		end else if (pick == 8) begin
			offer_cmd(8'($urandom), 8'($urandom), $urandom, 1'b1);
			n = (limit_ms < 60) ? $urandom_range(0, limit_ms + 1) : $urandom_range(0, 20);
			offer_ticks(n);
		end else begin
			n = $urandom_range(1, 4);
			repeat (n)
				offer(any_word(gsut_pkg::req_kind_t'(2'($urandom_range(0, 3)))), 1'b0);
		end
	endtask

	initial begin : stimulus
		gsut_pkg::req_t w;
		logic [15:0] tmo_pick;
		int unsigned phase_goal;
		bit paused;
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// idle bytes, idle tick, unused request
		w = '0;
		w.req_type = gsut_pkg::REQ_RX;
		offer(w, 1'b0);
		w = '1;
		w.req_type = gsut_pkg::REQ_RX;
		offer(w, 1'b0);
		offer(any_word(gsut_pkg::REQ_TICK), 1'b0);
		w = '1;
		w.req_type = gsut_pkg::req_kind_t'(REQ_UNUSED);
		offer(w, 1'b0);

		w = '0;
		w.req_type = gsut_pkg::REQ_CMD;
		offer(w, 1'b1);
		w = '1;
		w.req_type = gsut_pkg::REQ_CMD;
		offer(w, 1'b1);
		offer_reply(8'hFF, 8'hFF, 1'b1, 1'b0);
		// wait aborted by a new command
		offer_cmd(CMD_AUTOCAL, CAL_ENABLE, '0, 1'b1);
		offer_rx(gsut_pkg::SYNC_BYTE);
		offer_rx(CMD_READ);
		offer_cmd(CMD_RANGE, 8'h00, 32'd5000, 1'b1);
		offer_reply(8'($urandom), 8'($urandom), 1'b0, 1'b0);
		settle();

		// ticks under the reset timeout, then the extreme timeout settings
		send_idle = 1'b0;
		recv_idle = 1'b0;
		offer_cmd(CMD_READ, '0, '0, 1'b1);
		offer_ticks(8);
		set_timeout(16'd0);
		offer_cmd(CMD_READ, '0, '0, 1'b1);
		offer_ticks(1);
		set_timeout(16'd1);
		offer_cmd(CMD_READ, '0, '0, 1'b1);
		offer_rx(gsut_pkg::SYNC_BYTE);
		offer_ticks(1);
		set_timeout(16'hFFFF);
		offer_cmd(CMD_READ, '0, '0, 1'b1);
		offer_ticks(8);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: tmo_pick = 16'($urandom_range(2, 12));
				1: tmo_pick = 16'($urandom_range(20, 60));
				2: tmo_pick = 16'hFFFF;
				3: tmo_pick = 16'($urandom);
				4: tmo_pick = 16'd1;
				default: tmo_pick = 16'($urandom_range(8, 30));
			endcase
			set_timeout(tmo_pick);
			send_idle = (ph != 1) && (ph < 5);
			recv_idle = (ph != 1) && (ph < 5);
			if (ph == 2)
				hold_ask = 1'b1;
			phase_goal = items_made + 20;
			while (items_made < phase_goal) begin
				if (ph == 3 && !paused && items_made + 10 >= phase_goal) begin
					settle();
					paused = 1'b1;
				end
				random_exchange();
			end
		end

		settle();
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: gas_sensor_uart_transaction.f
design/gsut_pkg.sv
design/gsut_proc.sv
design/gsut_tx.sv
design/gas_sensor_uart_transaction.sv
test/testbench.sv
